@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define L2PC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// expression must never be true outside reset
`define L2PC_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define L2PC_ASSERT(label, prop, msg)
`define L2PC_NEVER(label, expr, msg)
`endif

`endif

@@ rtl/core/l2pc_pkg.sv @@
// types, constants and register codes of the l2 priority classifier
`timescale 1ns / 1ps

package l2pc_pkg;

	localparam int POS_W  = 5;
	localparam int PRIO_W = 3;
	localparam int MAP_W  = 48;
	localparam int DSCP_W = 6;

	localparam logic [POS_W-1:0] POS_OUTER_HI = 5'd12;
	localparam logic [POS_W-1:0] POS_OUTER_LO = 5'd13;
	localparam logic [POS_W-1:0] POS_TAG      = 5'd14;
	localparam logic [POS_W-1:0] POS_DSCP_UNT = 5'd15;
	localparam logic [POS_W-1:0] POS_INNER_HI = 5'd16;
	localparam logic [POS_W-1:0] POS_INNER_LO = 5'd17;
	localparam logic [POS_W-1:0] POS_DSCP_TAG = 5'd19;
	localparam logic [POS_W-1:0] POS_MAX      = 5'd31;

	localparam logic [15:0] TYPE_VLAN = 16'h8100;
	localparam logic [15:0] TYPE_IPV4 = 16'h0800;

	localparam logic [MAP_W-1:0] MAP_Q0_RST = 48'd4467856506880;
	localparam logic [MAP_W-1:0] MAP_Q1_RST = 48'd13403570053250;
	localparam logic [MAP_W-1:0] MAP_Q2_RST = 48'd26731961401604;
	localparam logic [MAP_W-1:0] MAP_Q3_RST = 48'd117440518;

	typedef enum logic [2:0] {
		REG_TRUST_PCP   = 3'd0,
		REG_DSCP_TRUST  = 3'd1,
		REG_DEFAULT_PRI = 3'd2,
		REG_DSCP_MAP_Q0 = 3'd3,
		REG_DSCP_MAP_Q1 = 3'd4,
		REG_DSCP_MAP_Q2 = 3'd5,
		REG_DSCP_MAP_Q3 = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic                        trust_pcp;
		logic                        dscp_trust;
		logic [PRIO_W-1:0]           base_prio;
		logic [3:0][MAP_W-1:0]       dscp_map;
	} l2pc_cfg_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} l2pc_word_t;

endpackage

@@ rtl/core/l2_priority_classifier_core.sv @@
// top level of the l2 priority classifier: config registers, input and result registers
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel  direction  handshake           payload
// in       sink       in_valid/in_stall   frame_byte[7:0], frame_end
// out      source     out_valid/out_stall priority_res[2:0]
// cfg      sink       cfg_wr_en           cfg_index[2:0], cfg_data[47:0]
//
// one byte per cycle while in_stall is low; the result is registered from the last byte
// path: input register, field capture and map lookup, result register
// reset clears config to defaults and the frame state to start of frame
// in_stall rises only while a last byte waits behind a result the sink has stalled
// middle bytes of a frame keep flowing while a result waits

module l2_priority_classifier_core
	import l2pc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        frame_byte,
	input  logic              frame_end,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PRIO_W-1:0] priority_res,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_index,
	input  logic [MAP_W-1:0]  cfg_data
);

	l2pc_cfg_t         cfg_q;
	l2pc_word_t        word_s1;
	logic              valid_s1;
	logic              go_s1, adv, load;
	logic [PRIO_W-1:0] prio;
	logic              out_valid_q;
	logic [PRIO_W-1:0] prio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trust_pcp   <= 1'b0;
			cfg_q.dscp_trust  <= 1'b0;
			cfg_q.base_prio   <= '0;
			cfg_q.dscp_map[0] <= MAP_Q0_RST;
			cfg_q.dscp_map[1] <= MAP_Q1_RST;
			cfg_q.dscp_map[2] <= MAP_Q2_RST;
			cfg_q.dscp_map[3] <= MAP_Q3_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TRUST_PCP:   cfg_q.trust_pcp   <= cfg_data[0];
				REG_DSCP_TRUST:  cfg_q.dscp_trust  <= cfg_data[0];
				REG_DEFAULT_PRI: cfg_q.base_prio   <= cfg_data[PRIO_W-1:0];
				REG_DSCP_MAP_Q0: cfg_q.dscp_map[0] <= cfg_data;
				REG_DSCP_MAP_Q1: cfg_q.dscp_map[1] <= cfg_data;
				REG_DSCP_MAP_Q2: cfg_q.dscp_map[2] <= cfg_data;
				REG_DSCP_MAP_Q3: cfg_q.dscp_map[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// only a last byte needs room in the result register
	assign go_s1    = !word_s1.last || !out_valid_q || !out_stall;
	assign adv      = valid_s1 && go_s1;
	assign in_stall = valid_s1 && !go_s1;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_s1.data <= frame_byte;
			word_s1.last <= frame_end;
		end
	end

	l2pc_classify u_classify (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.adv    (adv),
		.word   (word_s1),
		.prio   (prio)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && word_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && word_s1.last) prio_q <= prio;
	end

	assign out_valid    = out_valid_q;
	assign priority_res = prio_q;

	`L2PC_ASSERT(a_stall_cause, in_stall |-> (valid_s1 && word_s1.last && out_valid_q && out_stall), "input stalled without a blocked result")
	`L2PC_ASSERT(a_out_source, (out_valid_q && !$past(out_valid_q)) |-> $past(adv && word_s1.last), "result without a last byte")
	`L2PC_NEVER(a_no_overwrite, adv && word_s1.last && out_valid_q && out_stall, "pending result overwritten")

endmodule

@@ rtl/core/l2pc_classify.sv @@
// frame field capture and priority decision, one byte per cycle while adv is high
`timescale 1ns / 1ps
`include "assert_macros.svh"

module l2pc_classify
	import l2pc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  l2pc_cfg_t         cfg,
	input  logic              adv,
	input  l2pc_word_t        word,
	output logic [PRIO_W-1:0] prio
);

	logic [POS_W-1:0]  pos_q;
	logic [15:0]       outer_q, inner_q;
	logic [2:0]        pcp_q;
	logic [DSCP_W-1:0] dscp_q;

	logic [15:0]       outer_d, inner_d;
	logic [2:0]        pcp_d;
	logic [DSCP_W-1:0] dscp_d;
	logic              vlan_tag, ipv4;
	logic [MAP_W-1:0]  map_word;
	logic [PRIO_W-1:0] map_prio;

	// field capture at this byte position
	always_comb begin
		outer_d = outer_q;
		inner_d = inner_q;
		pcp_d   = pcp_q;
		dscp_d  = dscp_q;
		case (pos_q)
			POS_OUTER_HI: outer_d = {word.data, 8'h00};
			POS_OUTER_LO: outer_d = {outer_q[15:8], word.data};
			POS_TAG:      pcp_d   = word.data[7:5];
			POS_DSCP_UNT: begin
				if (outer_q != TYPE_VLAN) dscp_d = word.data[7:2];
			end
			POS_INNER_HI: inner_d = {word.data, 8'h00};
			POS_INNER_LO: inner_d = {inner_q[15:8], word.data};
			POS_DSCP_TAG: begin
				if (outer_q == TYPE_VLAN) dscp_d = word.data[7:2];
			end
			default: ;
		endcase
	end

	// frame length so far is pos_q + 1, so "n >= k" becomes "pos_q >= k - 1"
	always_comb begin
		map_word = cfg.dscp_map[dscp_d[5:4]];
		map_prio = PRIO_W'(map_word >> (dscp_d[3:0] * 6'd3));
		vlan_tag = (pos_q >= POS_OUTER_LO) && (outer_d == TYPE_VLAN);
		ipv4     = ((outer_d == TYPE_IPV4) && (pos_q >= POS_DSCP_UNT))
			|| (vlan_tag && (pos_q >= POS_DSCP_TAG) && (inner_d == TYPE_IPV4));
		prio = cfg.base_prio;
		if (cfg.trust_pcp && vlan_tag && (pos_q >= POS_TAG) && (pcp_d != 3'd0))
			prio = pcp_d;
		if (cfg.dscp_trust && (pos_q >= POS_OUTER_LO) && ipv4 && (dscp_d != '0))
			prio = map_prio;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			outer_q <= '0;
			inner_q <= '0;
			pcp_q   <= '0;
			dscp_q  <= '0;
		end else if (adv) begin
			if (word.last) begin
				pos_q   <= '0;
				outer_q <= '0;
				inner_q <= '0;
				pcp_q   <= '0;
				dscp_q  <= '0;
			end else begin
				if (pos_q != POS_MAX) pos_q <= pos_q + 1'b1;
				outer_q <= outer_d;
				inner_q <= inner_d;
				pcp_q   <= pcp_d;
				dscp_q  <= dscp_d;
			end
		end
	end

	`L2PC_ASSERT(a_pos_restart, (adv && word.last) |=> (pos_q == '0), "position not cleared at frame end")
	`L2PC_ASSERT(a_pos_step, (adv && !word.last && pos_q != POS_MAX) |=> (pos_q == $past(pos_q) + 1'b1), "position did not advance")
	`L2PC_ASSERT(a_pos_hold, !adv |=> $stable(pos_q), "position moved without a byte")

endmodule

@@ tb/l2_priority_classifier_core_tb.sv @@
// self-checking testbench for the l2 priority classifier core
`timescale 1ns / 1ps

module l2_priority_classifier_core_tb;
	import l2pc_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_BYTES = 100;
	localparam logic [2:0]  REG_UNUSED = 3'd7;
	localparam logic [15:0] TYPE_OTHER = 16'h86DD;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        frame_byte;
	logic              frame_end;
	logic              out_valid;
	logic              out_stall;
	logic [PRIO_W-1:0] priority_res;
	logic              cfg_wr_en;
	logic [2:0]        cfg_index;
	logic [MAP_W-1:0]  cfg_data;

	// expected configuration and per-frame capture state
	logic              cfg_trust_pcp;
	logic              cfg_dscp_trust;
	logic [PRIO_W-1:0] cfg_def_prio;
	logic [MAP_W-1:0]  cfg_map [4];
	logic [POS_W-1:0]  frm_pos;
	logic [15:0]       frm_outer;
	logic [15:0]       frm_inner;
	logic [2:0]        frm_pcp;
	logic [DSCP_W-1:0] frm_dscp;

	logic [PRIO_W-1:0] pending_prio [$];
	logic [7:0]        frame_buf [$];

	int mismatch_cnt  = 0;
	int bytes_sent    = 0;
	int frames_sent   = 0;
	int prios_checked = 0;
	int cfg_writes    = 0;
	int idle_cycles   = 0;
	int hold_cnt      = 0;
	bit tx_gaps       = 1'b1;
	bit rx_gaps       = 1'b1;

	l2_priority_classifier_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.frame_byte   (frame_byte),
		.frame_end    (frame_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.priority_res (priority_res),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		mismatch_cnt++;
		$display("mismatch %0d at %0t: %s", mismatch_cnt, $realtime, what);
	endtask

	function automatic logic [MAP_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[MAP_W-1:0];
	endfunction

	function automatic logic [PRIO_W-1:0] map_prio(input logic [DSCP_W-1:0] d);
		return cfg_map[d[5:4]][3*d[3:0] +: 3];
	endfunction

	task automatic clear_frame_state();
		frm_pos   = '0;
		frm_outer = '0;
		frm_inner = '0;
		frm_pcp   = '0;
		frm_dscp  = '0;
	endtask

	// field capture per byte; on the last byte the priority is queued
	task automatic classify_byte(input logic [7:0] b, input logic last);
		logic [POS_W-1:0]  pos;
		int                n;
		logic [PRIO_W-1:0] prio;
		logic              vlan_seen;
		logic              ipv4;
		pos = frm_pos;
		case (pos)
			POS_OUTER_HI: frm_outer = {b, 8'h00};
			POS_OUTER_LO: frm_outer[7:0] = b;
			POS_TAG:      frm_pcp = b[7:5];
			POS_DSCP_UNT: if (frm_outer != TYPE_VLAN) frm_dscp = b[7:2];
			POS_INNER_HI: frm_inner = {b, 8'h00};
			POS_INNER_LO: frm_inner[7:0] = b;
			POS_DSCP_TAG: if (frm_outer == TYPE_VLAN) frm_dscp = b[7:2];
			default: ;
		endcase
		if (frm_pos != POS_MAX)
			frm_pos = frm_pos + 1'b1;
		if (last) begin
			n = int'(pos) + 1;
			prio = cfg_def_prio;
			vlan_seen = n >= 14 && frm_outer == TYPE_VLAN;
			if (cfg_trust_pcp && vlan_seen && n >= 15 && frm_pcp != 3'd0)
				prio = frm_pcp;
			ipv4 = (n >= 16 && frm_outer == TYPE_IPV4) ||
				(vlan_seen && n >= 20 && frm_inner == TYPE_IPV4);
			if (cfg_dscp_trust && ipv4 && frm_dscp != '0)
				prio = map_prio(frm_dscp);
			pending_prio.push_back(prio);
			clear_frame_state();
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [MAP_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_TRUST_PCP:   cfg_trust_pcp  = data[0];
			REG_DSCP_TRUST:  cfg_dscp_trust = data[0];
			REG_DEFAULT_PRI: cfg_def_prio   = data[PRIO_W-1:0];
			REG_DSCP_MAP_Q0: cfg_map[0]     = data;
			REG_DSCP_MAP_Q1: cfg_map[1]     = data;
			REG_DSCP_MAP_Q2: cfg_map[2]     = data;
			REG_DSCP_MAP_Q3: cfg_map[3]     = data;
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// all seven registers, with junk in the unused upper bits
	task automatic apply_config(input logic tp, input logic td, input logic [2:0] dp,
			input logic [MAP_W-1:0] m0, input logic [MAP_W-1:0] m1,
			input logic [MAP_W-1:0] m2, input logic [MAP_W-1:0] m3);
		logic [MAP_W-1:0] junk;
		junk = rand48();
		write_reg(REG_TRUST_PCP, {junk[MAP_W-1:1], tp});
		junk = rand48();
		write_reg(REG_DSCP_TRUST, {junk[MAP_W-1:1], td});
		junk = rand48();
		write_reg(REG_DEFAULT_PRI, {junk[MAP_W-1:3], dp});
		write_reg(REG_DSCP_MAP_Q0, m0);
		write_reg(REG_DSCP_MAP_Q1, m1);
		write_reg(REG_DSCP_MAP_Q2, m2);
		write_reg(REG_DSCP_MAP_Q3, m3);
		write_reg(REG_UNUSED, rand48());
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while (tx_gaps && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		frame_byte <= b;
		frame_end  <= last;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
		classify_byte(b, last);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		frames_sent++;
	endtask

	// stop offering and wait until every priority is back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_prio.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic directed_frame(input int len, input logic [15:0] outer,
			input logic [7:0] tag, input logic [15:0] inner, input logic [7:0] tos,
			input logic [7:0] fill);
		frame_buf.delete();
		for (int i = 0; i < len; i++)
			frame_buf.push_back(fill);
		if (len > 12) frame_buf[12] = outer[15:8];
		if (len > 13) frame_buf[13] = outer[7:0];
		if (outer == TYPE_VLAN) begin
			if (len > 14) frame_buf[14] = tag;
			if (len > 16) frame_buf[16] = inner[15:8];
			if (len > 17) frame_buf[17] = inner[7:0];
			if (len > 19) frame_buf[19] = tos;
		end else if (len > 15) begin
			frame_buf[15] = tos;
		end
		send_frame();
	endtask

	// mostly well-formed headers with random content, the rest pure noise
	task automatic build_random_frame(input int max_len);
		int          len;
		int          sel;
		logic [15:0] outer;
		logic [15:0] inner;
		sel = $urandom_range(99);
		if (sel < 20)      len = $urandom_range(11, 1);
		else if (sel < 60) len = $urandom_range(21, 12);
		else if (sel < 90) len = $urandom_range(40, 22);
		else               len = $urandom_range(80, 41);
		if (len > max_len)
			len = $urandom_range(max_len, 1);
		frame_buf.delete();
		for (int i = 0; i < len; i++)
			frame_buf.push_back(8'($urandom_range(255)));
		if ($urandom_range(99) < 75) begin
			sel = $urandom_range(99);
			if (sel < 40)      outer = TYPE_VLAN;
			else if (sel < 75) outer = TYPE_IPV4;
			else if (sel < 88) outer = TYPE_OTHER;
			else               outer = 16'($urandom);
			sel = $urandom_range(99);
			if (sel < 60)      inner = TYPE_IPV4;
			else if (sel < 80) inner = TYPE_VLAN;
			else               inner = 16'($urandom);
			if (len > 12) frame_buf[12] = outer[15:8];
			if (len > 13) frame_buf[13] = outer[7:0];
			if (outer == TYPE_VLAN) begin
				if (len > 16) frame_buf[16] = inner[15:8];
				if (len > 17) frame_buf[17] = inner[7:0];
			end
		end
	endtask

	task automatic test_reset_defaults();
		// nothing trusted after reset, so every frame gets priority zero
		for (int i = 0; i < 2; i++) begin
			build_random_frame(30);
			send_frame();
		end
		drain();
	endtask

	task automatic test_directed();
		write_reg(REG_TRUST_PCP, 48'd1);
		write_reg(REG_DSCP_TRUST, 48'd1);
		write_reg(REG_DEFAULT_PRI, 48'd5);
		// map still at its reset contents here
		directed_frame(1,  TYPE_VLAN, 8'hE0, TYPE_IPV4, 8'hB8, 8'hFF);
		directed_frame(13, TYPE_VLAN, 8'hE0, TYPE_IPV4, 8'hB8, 8'hFF);
		directed_frame(14, TYPE_VLAN, 8'hE0, TYPE_IPV4, 8'hB8, 8'h00);
		directed_frame(15, TYPE_VLAN, 8'hE0, TYPE_IPV4, 8'hB8, 8'h00);
		directed_frame(15, TYPE_IPV4, 8'h45, TYPE_IPV4, 8'hB8, 8'h00);
		directed_frame(16, TYPE_IPV4, 8'h45, TYPE_IPV4, 8'hB8, 8'h00);
		directed_frame(16, TYPE_IPV4, 8'h45, TYPE_IPV4, 8'h03, 8'hFF);
		directed_frame(60, TYPE_IPV4, 8'h45, TYPE_IPV4, 8'hFF, 8'h00);
		// zero pcp falls through to the dscp map
		directed_frame(20, TYPE_VLAN, 8'h1F, TYPE_IPV4, 8'h28, 8'h00);
		directed_frame(19, TYPE_VLAN, 8'h60, TYPE_IPV4, 8'h28, 8'h00);
		// two tags and a non-ip inner type keep the pcp
		directed_frame(20, TYPE_VLAN, 8'h60, TYPE_VLAN, 8'h28, 8'hFF);
		directed_frame(24, TYPE_VLAN, 8'h60, TYPE_OTHER, 8'h28, 8'hFF);
		directed_frame(20, TYPE_VLAN, 8'hA0, TYPE_IPV4, 8'h00, 8'h00);
		directed_frame(40, TYPE_OTHER, 8'hFF, TYPE_IPV4, 8'hB8, 8'h00);
		// long frame, position counter saturates
		directed_frame(70, TYPE_VLAN, 8'hFF, TYPE_IPV4, 8'hFC, 8'hFF);
		directed_frame(70, TYPE_VLAN, 8'hFF, TYPE_IPV4, 8'h40, 8'h00);
		drain();
		write_reg(REG_DSCP_TRUST, 48'd0);
		directed_frame(20, TYPE_VLAN, 8'hE0, TYPE_IPV4, 8'hB8, 8'h00);
		drain();
		write_reg(REG_TRUST_PCP, 48'd0);
		write_reg(REG_DSCP_TRUST, 48'd1);
		directed_frame(20, TYPE_VLAN, 8'hE0, TYPE_IPV4, 8'hB8, 8'h00);
		drain();
		write_reg(REG_DSCP_TRUST, 48'hFFFF_FFFF_FFFE);
		directed_frame(20, TYPE_VLAN, 8'hE0, TYPE_IPV4, 8'hB8, 8'h00);
		drain();
	endtask

	task automatic test_config_sweep();
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: apply_config(1'b1, 1'b1, 3'd0, '0, '0, '0, '0);
				1: apply_config(1'b1, 1'b1, 3'd7, '1, '1, '1, '1);
				2: apply_config(1'b0, 1'b1, 3'd7, MAP_Q0_RST, MAP_Q1_RST,
					MAP_Q2_RST, MAP_Q3_RST);
				3: apply_config(1'b1, 1'b0, 3'd0, rand48(), rand48(), rand48(), rand48());
				default: apply_config(1'b0, 1'b0, 3'd3, rand48(), rand48(), rand48(),
					rand48());
			endcase
			for (int i = 0; i < 3; i++) begin
				build_random_frame(40);
				send_frame();
			end
			drain();
		end
	endtask

	task automatic test_backpressure();
		apply_config(1'b1, 1'b1, 3'($urandom_range(7)), rand48(), rand48(), rand48(),
			rand48());
		// sink holds off while short frames keep coming
		hold_cnt = HOLD_CYCLES;
		for (int i = 0; i < 40; i++) begin
			build_random_frame(3);
			send_frame();
		end
		drain();
		for (int i = 0; i < 4; i++) begin
			build_random_frame(25);
			send_frame();
		end
		drain();
	endtask

	task automatic test_no_gaps();
		int start;
		start = bytes_sent;
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		while (bytes_sent - start < 120) begin
			build_random_frame(30);
			send_frame();
		end
		drain();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	task automatic test_random_traffic();
		int start;
		int since_cfg;
		start = bytes_sent;
		since_cfg = 0;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if (since_cfg == 12) begin
				drain();
				apply_config($urandom_range(99) < 75, $urandom_range(99) < 75,
					3'($urandom_range(7)), rand48(), rand48(), rand48(), rand48());
				since_cfg = 0;
			end
			build_random_frame(80);
			send_frame();
			since_cfg++;
		end
		drain();
	endtask

	// sink side: long hold-off when requested, random stalls otherwise
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			out_stall <= 1'b1;
			hold_cnt  <= hold_cnt - 1;
		end else begin
			out_stall <= rx_gaps && ($urandom_range(99) < 28);
		end
	end

	always @(posedge clk) begin : check_result
		logic [PRIO_W-1:0] want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_prio.size() == 0) begin
				report_mismatch($sformatf("priority %0d with no frame outstanding",
					priority_res));
			end else begin
				want = pending_prio.pop_front();
				if (priority_res !== want)
					report_mismatch($sformatf("priority %0d, expected %0d",
						priority_res, want));
				prios_checked++;
			end
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
		$display("l2_priority_classifier_core_tb NOT OK");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		frame_byte = '0;
		frame_end  = 1'b0;
		out_stall  = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		cfg_trust_pcp  = 1'b0;
		cfg_dscp_trust = 1'b0;
		cfg_def_prio   = '0;
		cfg_map[0] = MAP_Q0_RST;
		cfg_map[1] = MAP_Q1_RST;
		cfg_map[2] = MAP_Q2_RST;
		cfg_map[3] = MAP_Q3_RST;
		clear_frame_state();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_directed();
		test_config_sweep();
		test_backpressure();
		test_no_gaps();
		test_random_traffic();

		repeat (10) @(posedge clk);
		$display("covered %0d frames in %0d bytes, %0d priorities compared, %0d register writes",
			frames_sent, bytes_sent, prios_checked, cfg_writes);
		$display("short, long, tagged, double-tagged and ipv4 frames; %0d-cycle sink hold-off",
			HOLD_CYCLES);
		if (mismatch_cnt == 0)
			$display("l2_priority_classifier_core_tb OK");
		else
			$display("l2_priority_classifier_core_tb NOT OK");
		$finish;
	end

endmodule
